// ===== hw/rtl/ptr_pkg.sv =====
// ----------------------------------------------------------------------------
// ptr_pkg - shared types and constants of the planar tile pixel renderer
// Map geometry, item codes, colour table and the structs between stages.
// ----------------------------------------------------------------------------
package ptr_pkg;

    // map geometry
    localparam int MAP_COLS   = 48;
    localparam int MAP_ROWS   = 32;
    localparam int CELL_COUNT = MAP_COLS * MAP_ROWS;
    localparam int CELL_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;

    // pattern memory, split into low plane and high plane banks
    localparam int PAT_AW  = 12;
    localparam int BANK_AW = PAT_AW - 1;

    // item codes
    typedef enum logic [1:0] {
        FUNC_WR_PATTERN = 2'd0,
        FUNC_WR_TILE    = 2'd1,
        FUNC_WR_PALETTE = 2'd2,
        FUNC_RENDER     = 2'd3
    } t_func;

    // colour modes, any other code renders as system colours
    localparam logic [1:0] MODE_CELL   = 2'd0;
    localparam logic [1:0] MODE_BRUSH  = 2'd1;
    localparam logic [1:0] MODE_SYSTEM = 2'd2;

    localparam logic [4:0]  SYSTEM_BASE  = 5'd16;
    localparam logic [15:0] BRUSH_RESET  = 16'h3290;
    localparam int          COLOUR_COUNT = 20;

    // user colours 0..15, system colours 16..19
    localparam logic [23:0] COLOUR_TABLE [COLOUR_COUNT] = '{
        24'hf5f4eb, 24'h000000, 24'h191028, 24'h46af45,
        24'ha1d685, 24'h453e78, 24'h7664fe, 24'h833129,
        24'h9ec2e8, 24'hdc534b, 24'he18d79, 24'hd6b97b,
        24'he9d8a1, 24'h216c4b, 24'hd365c8, 24'hafaab9,
        24'hdddddd, 24'h333333, 24'h666666, 24'h999999
    };

    // item after the input register
    typedef struct packed {
        logic              valid;
        t_func             func;
        logic [PAT_AW-1:0] pattern_address;
        logic [7:0]        write_byte;
        logic [CELL_W-1:0] cell_num;
        logic              in_map;
        logic [1:0]        palette_slot;
        logic [3:0]        palette_index;
        logic [7:0]        tile_id;
        logic [2:0]        pixel_row;
        logic [2:0]        pixel_col;
        logic [1:0]        colour_mode;
    } t_cell_item;

    // item after the map access
    typedef struct packed {
        logic              valid;
        t_func             func;
        logic [PAT_AW-1:0] pattern_address;
        logic [7:0]        write_byte;
        logic              in_map;
        logic [7:0]        tile_id;
        logic [2:0]        pixel_row;
        logic [2:0]        pixel_col;
        logic [1:0]        colour_mode;
    } t_pattern_item;

    // render after the pattern access
    typedef struct packed {
        logic        valid;
        logic        in_map;
        logic [2:0]  pixel_col;
        logic [1:0]  colour_mode;
        logic [15:0] pal_row;
    } t_colour_item;

endpackage

// ===== hw/rtl/ptr_cell_stage.sv =====
// ----------------------------------------------------------------------------
// ptr_cell_stage - input register, tile map and cell palette access
// Registers each transfer, works out the cell number and applies map and
// palette writes; clears both stores after reset.
// ----------------------------------------------------------------------------
module ptr_cell_stage
    import ptr_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic [1:0]          i_func,
    input  logic [PAT_AW-1:0]   i_pattern_address,
    input  logic [7:0]          i_write_byte,
    input  logic [5:0]          i_cell_col,
    input  logic [4:0]          i_cell_row,
    input  logic [1:0]          i_palette_slot,
    input  logic [3:0]          i_palette_index,
    input  logic [7:0]          i_tile_id,
    input  logic [2:0]          i_pixel_row,
    input  logic [2:0]          i_pixel_col,
    input  logic [1:0]          i_colour_mode,
    output logic                o_busy,
    output t_pattern_item       o_item,
    output logic [7:0]          o_map_tile,
    output logic [15:0]         o_pal_row
);

    logic [7:0]        mem_map [CELL_COUNT];
    logic [15:0]       mem_pal [CELL_COUNT];

    t_cell_item        r_a, n_a;
    t_pattern_item     r_b, n_b;
    logic [7:0]        r_map_tile;
    logic [15:0]       r_pal_row;
    logic              r_clearing, n_clearing;
    logic [CELL_W-1:0] r_clr_addr, n_clr_addr;

    logic              accept;
    logic              in_inside;
    logic              map_we;
    logic [3:0]        pal_we;
    logic [CELL_W-1:0] wr_addr;
    logic [7:0]        map_wdata;
    logic [3:0]        pal_wdata;

    assign accept = start && !r_clearing;
    assign o_busy = r_clearing;

    // input register with cell number, cells outside the map fold to zero
    always_comb begin
        in_inside = (32'(i_cell_col) < MAP_COLS) && (32'(i_cell_row) < MAP_ROWS);
        n_a.valid           = accept;
        n_a.func            = t_func'(i_func);
        n_a.pattern_address = i_pattern_address;
        n_a.write_byte      = i_write_byte;
        n_a.cell_num        = in_inside ? CELL_W'(32'(i_cell_row) * MAP_COLS + 32'(i_cell_col))
                                        : '0;
        n_a.in_map          = in_inside;
        n_a.palette_slot    = i_palette_slot;
        n_a.palette_index   = i_palette_index;
        n_a.tile_id         = i_tile_id;
        n_a.pixel_row       = i_pixel_row;
        n_a.pixel_col       = i_pixel_col;
        n_a.colour_mode     = i_colour_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= '0;
        end else begin
            r_a <= n_a;
        end
    end

    // clearing pass over all cells after reset
    always_comb begin
        n_clearing = r_clearing;
        n_clr_addr = r_clr_addr;
        if (r_clearing) begin
            n_clr_addr = r_clr_addr + 1'b1;
            if (r_clr_addr == CELL_W'(CELL_COUNT - 1)) begin
                n_clearing = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            r_clearing <= n_clearing;
            r_clr_addr <= n_clr_addr;
        end
    end

    // write port selection
    always_comb begin
        if (r_clearing) begin
            wr_addr   = r_clr_addr;
            map_we    = 1'b1;
            map_wdata = '0;
            pal_we    = 4'hf;
            pal_wdata = '0;
        end else begin
            wr_addr   = r_a.cell_num;
            map_we    = r_a.valid && r_a.in_map && (r_a.func == FUNC_WR_TILE);
            map_wdata = r_a.write_byte;
            pal_we    = (r_a.valid && r_a.in_map && (r_a.func == FUNC_WR_PALETTE))
                        ? (4'b0001 << r_a.palette_slot) : 4'b0000;
            pal_wdata = r_a.palette_index;
        end
    end

    // map and palette stores, read data registered
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            mem_map[wr_addr] <= map_wdata;
        end
        for (int k = 0; k < 4; k++) begin
            if (pal_we[k]) begin
                mem_pal[wr_addr][k*4 +: 4] <= pal_wdata;
            end
        end
        r_map_tile <= mem_map[r_a.cell_num];
        r_pal_row  <= mem_pal[r_a.cell_num];
    end

    // item travels on to the pattern access
    always_comb begin
        n_b.valid           = r_a.valid;
        n_b.func            = r_a.func;
        n_b.pattern_address = r_a.pattern_address;
        n_b.write_byte      = r_a.write_byte;
        n_b.in_map          = r_a.in_map;
        n_b.tile_id         = r_a.tile_id;
        n_b.pixel_row       = r_a.pixel_row;
        n_b.pixel_col       = r_a.pixel_col;
        n_b.colour_mode     = r_a.colour_mode;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
        end else begin
            r_b <= n_b;
        end
    end

    assign o_item     = r_b;
    assign o_map_tile = r_map_tile;
    assign o_pal_row  = r_pal_row;

endmodule

// ===== hw/rtl/ptr_pattern_stage.sv =====
// ----------------------------------------------------------------------------
// ptr_pattern_stage - pattern memory access
// Resolves the tile, applies pattern writes and reads both plane bytes of
// the pixel row from the low and high plane banks.
// ----------------------------------------------------------------------------
module ptr_pattern_stage
    import ptr_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_pattern_item  i_item,
    input  logic [7:0]     i_map_tile,
    input  logic [15:0]    i_pal_row,
    output t_colour_item   o_item,
    output logic [7:0]     o_lo_byte,
    output logic [7:0]     o_hi_byte
);

    logic [7:0]         mem_lo [2**BANK_AW];
    logic [7:0]         mem_hi [2**BANK_AW];

    t_colour_item       r_c, n_c;
    logic [7:0]         r_lo_byte;
    logic [7:0]         r_hi_byte;

    logic [7:0]         tile;
    logic [BANK_AW-1:0] rd_idx;
    logic [BANK_AW-1:0] wr_idx;
    logic               pat_we;
    logic               we_lo;
    logic               we_hi;

    // tile from the map cell in cell mode, else the given tile
    always_comb begin
        if (i_item.colour_mode == MODE_CELL) begin
            tile = i_item.in_map ? i_map_tile : 8'd0;
        end else begin
            tile = i_item.tile_id;
        end
        rd_idx = {tile, i_item.pixel_row};
    end

    // address bit 3 picks the plane bank
    assign wr_idx = {i_item.pattern_address[PAT_AW-1:4], i_item.pattern_address[2:0]};
    assign pat_we = i_item.valid && (i_item.func == FUNC_WR_PATTERN);
    assign we_lo  = pat_we && !i_item.pattern_address[3];
    assign we_hi  = pat_we &&  i_item.pattern_address[3];

    always_ff @(posedge i_clk) begin
        if (we_lo) begin
            mem_lo[wr_idx] <= i_item.write_byte;
        end
        if (we_hi) begin
            mem_hi[wr_idx] <= i_item.write_byte;
        end
        r_lo_byte <= mem_lo[rd_idx];
        r_hi_byte <= mem_hi[rd_idx];
    end

    // only renders go on from here
    always_comb begin
        n_c.valid       = i_item.valid && (i_item.func == FUNC_RENDER);
        n_c.in_map      = i_item.in_map;
        n_c.pixel_col   = i_item.pixel_col;
        n_c.colour_mode = i_item.colour_mode;
        n_c.pal_row     = i_pal_row;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c <= '0;
        end else begin
            r_c <= n_c;
        end
    end

    assign o_item    = r_c;
    assign o_lo_byte = r_lo_byte;
    assign o_hi_byte = r_hi_byte;

endmodule

// ===== hw/rtl/ptr_colour_stage.sv =====
// ----------------------------------------------------------------------------
// ptr_colour_stage - pixel slot, palette lookup and result register
// Picks the 2-bit slot from the plane bytes, maps it to a colour index and
// an RGB value; holds the brush palette register.
// ----------------------------------------------------------------------------
module ptr_colour_stage
    import ptr_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_colour_item  i_item,
    input  logic [7:0]    i_lo_byte,
    input  logic [7:0]    i_hi_byte,
    input  logic          i_cfg_we,
    input  logic [15:0]   i_cfg_data,
    output logic          o_valid,
    output logic [23:0]   o_colour_rgb,
    output logic [1:0]    o_colour_slot
);

    logic [15:0] r_brush;
    logic        r_valid;
    logic [23:0] r_rgb, n_rgb;
    logic [1:0]  r_slot, n_slot;

    logic [2:0]  bit_sel;
    logic [4:0]  colour_index;

    // brush palette register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_brush <= BRUSH_RESET;
        end else if (i_cfg_we) begin
            r_brush <= i_cfg_data;
        end
    end

    // column 0 is bit 7 of each plane
    assign bit_sel = ~i_item.pixel_col;
    assign n_slot  = {i_hi_byte[bit_sel], i_lo_byte[bit_sel]};

    // colour index per mode
    always_comb begin
        case (i_item.colour_mode)
            MODE_CELL: begin
                colour_index = i_item.in_map ? {1'b0, i_item.pal_row[{n_slot, 2'b00} +: 4]}
                                             : 5'd0;
            end
            MODE_BRUSH: begin
                colour_index = {1'b0, r_brush[{n_slot, 2'b00} +: 4]};
            end
            default: begin
                colour_index = SYSTEM_BASE + 5'(n_slot);
            end
        endcase
        n_rgb = COLOUR_TABLE[colour_index];
    end

    // result register, one strobe per render
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rgb  <= n_rgb;
        r_slot <= n_slot;
    end

    assign o_valid       = r_valid;
    assign o_colour_rgb  = r_rgb;
    assign o_colour_slot = r_slot;

endmodule

// ===== hw/rtl/planar_tile_pixel_renderer.sv =====
// ----------------------------------------------------------------------------
// planar_tile_pixel_renderer - tile map renderer, 2 bits per pixel in planes
// Pattern, map and palette writes plus pixel renders through a four stage
// pipeline with a registered result.
// ----------------------------------------------------------------------------
// One transfer is taken on every clock edge with start high and busy low, so
// the block sustains one item per cycle. A render gives its result on
// o_valid after passing the input register, map and palette access,
// pattern access and colour lookup, held for one cycle only: the receiver
// cannot stall it. Writes give no result. After reset busy stays high
// while the tile map and cell palettes are cleared one cell per cycle.
// The user must write the brush palette through i_cfg_we and i_cfg_data
// only while no render is in flight; the block does not enforce this.
// Pattern bytes read before being written are undefined.
module planar_tile_pixel_renderer
    import ptr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        i_func,
    input  logic [PAT_AW-1:0] i_pattern_address,
    input  logic [7:0]        i_write_byte,
    input  logic [5:0]        i_cell_col,
    input  logic [4:0]        i_cell_row,
    input  logic [1:0]        i_palette_slot,
    input  logic [3:0]        i_palette_index,
    input  logic [7:0]        i_tile_id,
    input  logic [2:0]        i_pixel_row,
    input  logic [2:0]        i_pixel_col,
    input  logic [1:0]        i_colour_mode,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output logic              o_valid,
    output logic [23:0]       o_colour_rgb,
    output logic [1:0]        o_colour_slot
);

    t_pattern_item pat_item;
    t_colour_item  col_item;
    logic [7:0]    map_tile;
    logic [15:0]   pal_row;
    logic [7:0]    lo_byte;
    logic [7:0]    hi_byte;

    // input register and map access
    ptr_cell_stage u_cell (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .i_func            (i_func),
        .i_pattern_address (i_pattern_address),
        .i_write_byte      (i_write_byte),
        .i_cell_col        (i_cell_col),
        .i_cell_row        (i_cell_row),
        .i_palette_slot    (i_palette_slot),
        .i_palette_index   (i_palette_index),
        .i_tile_id         (i_tile_id),
        .i_pixel_row       (i_pixel_row),
        .i_pixel_col       (i_pixel_col),
        .i_colour_mode     (i_colour_mode),
        .o_busy            (busy),
        .o_item            (pat_item),
        .o_map_tile        (map_tile),
        .o_pal_row         (pal_row)
    );

    // pattern access
    ptr_pattern_stage u_pattern (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_item    (pat_item),
        .i_map_tile(map_tile),
        .i_pal_row (pal_row),
        .o_item    (col_item),
        .o_lo_byte (lo_byte),
        .o_hi_byte (hi_byte)
    );

    // colour lookup and result
    ptr_colour_stage u_colour (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (col_item),
        .i_lo_byte    (lo_byte),
        .i_hi_byte    (hi_byte),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_colour_rgb (o_colour_rgb),
        .o_colour_slot(o_colour_slot)
    );

endmodule

// ===== hw/rtl/ptr_checker.sv =====
// ----------------------------------------------------------------------------
// ptr_checker - port level checks of the planar tile pixel renderer
// Result timing, clearing pass and system colour output, bound to the top.
// ----------------------------------------------------------------------------
module ptr_checker
    import ptr_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              start,
    input logic              busy,
    input logic [1:0]        i_func,
    input logic [1:0]        i_colour_mode,
    input logic              o_valid,
    input logic [23:0]       o_colour_rgb,
    input logic [1:0]        o_colour_slot
);

    logic render_in;
    logic system_in;

    assign render_in = start && !busy && (i_func == FUNC_RENDER);
    assign system_in = render_in && (i_colour_mode == MODE_SYSTEM);

    // clearing pass starts after reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> busy)
        else $error("busy low after reset");

    // every render transfer gives one result
    a_render_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        render_in |-> ##4 o_valid)
        else $error("render without result");

    // no result without an earlier render
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(render_in, 4))
        else $error("result without render");

    // system colours follow the slot
    a_system_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && $past(system_in, 4))
        |-> (o_colour_rgb == COLOUR_TABLE[SYSTEM_BASE + 5'(o_colour_slot)]))
        else $error("wrong system colour");

endmodule

bind planar_tile_pixel_renderer ptr_checker u_checker (.*);

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb - self-checking testbench of the planar tile pixel renderer
// Directed table, then random writes and renders. Expected pixels come from
// the table's checked rows or a behavioural model of the map, palettes and
// pattern planes. Each expected pixel is checked against the strobed result
// in order, under random start gaps and several brush palette settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ptr_pkg::*;

    localparam int ITEM_TOTAL    = 850;
    localparam int DIR_ROWS      = 23;
    localparam int SETTLE_CYCLES = 8;
    localparam int PAT_BYTES     = 1 << PAT_AW;

    // unnamed mode code, renders as system colours
    localparam logic [1:0] MODE_SPARE = 2'd3;

    typedef struct packed {
        t_func             func;
        logic [PAT_AW-1:0] pattern_address;
        logic [7:0]        write_byte;
        logic [5:0]        cell_col;
        logic [4:0]        cell_row;
        logic [1:0]        palette_slot;
        logic [3:0]        palette_index;
        logic [7:0]        tile_id;
        logic [2:0]        pixel_row;
        logic [2:0]        pixel_col;
        logic [1:0]        colour_mode;
    } t_pix_item;

    typedef struct packed {
        logic [23:0] rgb;
        logic [1:0]  slot;
    } t_pixel;

    typedef struct packed {
        t_pix_item it;
        logic      chk;
        t_pixel    want;
    } t_dir_row;

    // user colours 0..15, system colours 16..19
    localparam logic [23:0] PIXEL_COLOURS [20] = '{
        24'hf5f4eb, 24'h000000, 24'h191028, 24'h46af45,
        24'ha1d685, 24'h453e78, 24'h7664fe, 24'h833129,
        24'h9ec2e8, 24'hdc534b, 24'he18d79, 24'hd6b97b,
        24'he9d8a1, 24'h216c4b, 24'hd365c8, 24'hafaab9,
        24'hdddddd, 24'h333333, 24'h666666, 24'h999999
    };

    // directed table: extremes, every item code, outside cells, every mode
    localparam t_dir_row DIRECTED [DIR_ROWS] = '{
        '{'{FUNC_WR_PATTERN, 12'd0, 8'hf0, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_WR_PATTERN, 12'd8, 8'hcc, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b1, '{24'hf5f4eb, 2'd3}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd2,
            MODE_BRUSH}, 1'b1, '{24'hdc534b, 2'd1}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd4,
            MODE_SYSTEM}, 1'b1, '{24'h666666, 2'd2}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd7,
            MODE_SPARE}, 1'b1, '{24'hdddddd, 2'd0}},
        '{'{FUNC_WR_PATTERN, 12'd4095, 8'h01, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_WR_PATTERN, 12'd4087, 8'h80, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd255, 3'd7, 3'd0,
            MODE_SYSTEM}, 1'b1, '{24'h333333, 2'd1}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd255, 3'd7, 3'd7,
            MODE_SYSTEM}, 1'b1, '{24'h666666, 2'd2}},
        '{'{FUNC_WR_TILE, 12'd0, 8'hff, 6'd47, 5'd31, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_WR_PALETTE, 12'd0, 8'h00, 6'd47, 5'd31, 2'd1, 4'd15, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd47, 5'd31, 2'd0, 4'd0, 8'd0, 3'd7, 3'd0,
            MODE_CELL}, 1'b1, '{24'hafaab9, 2'd1}},
        '{'{FUNC_WR_TILE, 12'd0, 8'hff, 6'd48, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_WR_PALETTE, 12'd0, 8'h00, 6'd63, 5'd31, 2'd0, 4'd15, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd63, 5'd31, 2'd0, 4'd0, 8'd0, 3'd0, 3'd7,
            MODE_CELL}, 1'b1, '{24'hf5f4eb, 2'd0}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd48, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b1, '{24'hf5f4eb, 2'd3}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd1, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b1, '{24'hf5f4eb, 2'd3}},
        '{'{FUNC_WR_PALETTE, 12'd0, 8'h00, 6'd0, 5'd0, 2'd3, 4'd15, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b0, '{24'h000000, 2'd0}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_CELL}, 1'b1, '{24'hafaab9, 2'd3}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd4,
            MODE_BRUSH}, 1'b1, '{24'h191028, 2'd2}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd0,
            MODE_BRUSH}, 1'b1, '{24'h46af45, 2'd3}},
        '{'{FUNC_RENDER, 12'd0, 8'h00, 6'd0, 5'd0, 2'd0, 4'd0, 8'd0, 3'd0, 3'd7,
            MODE_BRUSH}, 1'b1, '{24'hf5f4eb, 2'd0}}
    };

    logic                i_clk;
    logic                i_rst_n;
    logic                start;
    logic                busy;
    logic [1:0]          i_func;
    logic [PAT_AW-1:0]   i_pattern_address;
    logic [7:0]          i_write_byte;
    logic [5:0]          i_cell_col;
    logic [4:0]          i_cell_row;
    logic [1:0]          i_palette_slot;
    logic [3:0]          i_palette_index;
    logic [7:0]          i_tile_id;
    logic [2:0]          i_pixel_row;
    logic [2:0]          i_pixel_col;
    logic [1:0]          i_colour_mode;
    logic                i_cfg_we;
    logic [15:0]         i_cfg_data;
    logic                o_valid;
    logic [23:0]         o_colour_rgb;
    logic [1:0]          o_colour_slot;

    // behavioural copy of the block state
    logic [7:0]  pat_bytes    [PAT_BYTES];
    bit          pat_loaded   [PAT_BYTES];
    logic [7:0]  map_tiles    [CELL_COUNT];
    logic [3:0]  cell_colours [CELL_COUNT*4];
    logic [15:0] brush_model;

    t_pixel due_pixels [$];
    int     mismatch_count = 0;
    int     items_sent     = 0;
    bit     idle_on        = 1'b1;

    planar_tile_pixel_renderer DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_func            (i_func),
        .i_pattern_address (i_pattern_address),
        .i_write_byte      (i_write_byte),
        .i_cell_col        (i_cell_col),
        .i_cell_row        (i_cell_row),
        .i_palette_slot    (i_palette_slot),
        .i_palette_index   (i_palette_index),
        .i_tile_id         (i_tile_id),
        .i_pixel_row       (i_pixel_row),
        .i_pixel_col       (i_pixel_col),
        .i_colour_mode     (i_colour_mode),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .o_valid           (o_valid),
        .o_colour_rgb      (o_colour_rgb),
        .o_colour_slot     (o_colour_slot)
    );

    // clock
    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // tile a render reads: map cell tile in mode 0, else the given tile
    function automatic logic [7:0] render_tile(input t_pix_item it);
        if (it.colour_mode != MODE_CELL) return it.tile_id;
        if (it.cell_col < MAP_COLS && it.cell_row < MAP_ROWS)
            return map_tiles[it.cell_row * MAP_COLS + it.cell_col];
        return 8'd0;
    endfunction

    // apply one item to the model state, returns 1 with the pixel for a render
    function automatic bit tile_render_step(input t_pix_item it, output t_pixel px);
        bit                in_map;
        int                cell_num;
        int                bitpos;
        logic [PAT_AW-1:0] lo_addr;
        logic [1:0]        slot;
        logic [15:0]       brush_shift;
        logic [4:0]        colour_idx;
        in_map   = (it.cell_col < MAP_COLS) && (it.cell_row < MAP_ROWS);
        cell_num = it.cell_row * MAP_COLS + it.cell_col;
        px       = '0;
        if (it.func == FUNC_WR_PATTERN) begin
            pat_bytes[it.pattern_address]  = it.write_byte;
            pat_loaded[it.pattern_address] = 1'b1;
            return 1'b0;
        end
        if (it.func == FUNC_WR_TILE) begin
            if (in_map) map_tiles[cell_num] = it.write_byte;
            return 1'b0;
        end
        if (it.func == FUNC_WR_PALETTE) begin
            if (in_map) cell_colours[cell_num*4 + it.palette_slot] = it.palette_index;
            return 1'b0;
        end
        // render: low plane at row, high plane eight bytes on
        lo_addr = {render_tile(it), 1'b0, it.pixel_row};
        bitpos  = 7 - it.pixel_col;
        slot    = {pat_bytes[lo_addr | PAT_AW'(8)][bitpos], pat_bytes[lo_addr][bitpos]};
        if (it.colour_mode == MODE_CELL) begin
            colour_idx = in_map ? {1'b0, cell_colours[cell_num*4 + slot]} : 5'd0;
        end else if (it.colour_mode == MODE_BRUSH) begin
            brush_shift = brush_model >> (slot * 4);
            colour_idx  = {1'b0, brush_shift[3:0]};
        end else begin
            colour_idx = SYSTEM_BASE + 5'(slot);
        end
        px.rgb  = PIXEL_COLOURS[colour_idx];
        px.slot = slot;
        return 1'b1;
    endfunction

    // tile numbers lean towards a few tiles so patterns get reused
    function automatic logic [7:0] pick_tile();
        return ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    endfunction

    function automatic t_pix_item random_item();
        t_pix_item it;
        int        pick;
        it   = '0;
        pick = $urandom_range(0, 99);
        if (pick < 20)      it.func = FUNC_WR_PATTERN;
        else if (pick < 35) it.func = FUNC_WR_TILE;
        else if (pick < 50) it.func = FUNC_WR_PALETTE;
        else                it.func = FUNC_RENDER;
        it.pattern_address = ($urandom_range(0, 3) == 0) ? PAT_AW'($urandom)
                                                         : PAT_AW'($urandom_range(0, 127));
        it.write_byte = (it.func == FUNC_WR_TILE) ? pick_tile() : 8'($urandom);
        // cells mostly in a few corners, some outside the map
        case ($urandom_range(0, 3))
            0: it.cell_col = 6'($urandom_range(0, 3));
            1: it.cell_col = 6'($urandom_range(44, 47));
            2: it.cell_col = 6'($urandom_range(0, 47));
            default: it.cell_col = 6'($urandom_range(48, 63));
        endcase
        it.cell_row = ($urandom_range(0, 1) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom);
        it.palette_slot  = 2'($urandom);
        it.palette_index = 4'($urandom);
        it.tile_id       = pick_tile();
        it.pixel_row     = 3'($urandom);
        it.pixel_col     = 3'($urandom);
        it.colour_mode   = 2'($urandom);
        return it;
    endfunction

    // drive one item and hold it until the transfer
    task automatic send_item(input t_pix_item it, input logic chk, input t_pixel want);
        t_pixel px;
        i_func            <= it.func;
        i_pattern_address <= it.pattern_address;
        i_write_byte      <= it.write_byte;
        i_cell_col        <= it.cell_col;
        i_cell_row        <= it.cell_row;
        i_palette_slot    <= it.palette_slot;
        i_palette_index   <= it.palette_index;
        i_tile_id         <= it.tile_id;
        i_pixel_row       <= it.pixel_row;
        i_pixel_col       <= it.pixel_col;
        i_colour_mode     <= it.colour_mode;
        start             <= 1'b1;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        if (tile_render_step(it, px)) due_pixels.push_back(chk ? want : px);
        items_sent++;
    endtask

    task automatic maybe_idle();
        if (idle_on && $urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
    endtask

    // let every pending pixel arrive and queued writes retire
    task automatic drain_pipe();
        start <= 1'b0;
        while (due_pixels.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_brush(input logic [15:0] value);
        i_cfg_data <= value;
        i_cfg_we   <= 1'b1;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        brush_model = value;
    endtask

    // result check, one strobe per expected pixel in order
    always @(posedge i_clk) begin
        t_pixel want;
        if (i_rst_n && o_valid) begin
            if (due_pixels.size() == 0) begin
                $error("pixel with none expected: colour_rgb %h colour_slot %0d",
                       o_colour_rgb, o_colour_slot);
                mismatch_count++;
            end else begin
                want = due_pixels.pop_front();
                if (o_colour_rgb !== want.rgb) begin
                    $error("colour_rgb: expected %h, actual %h", want.rgb, o_colour_rgb);
                    mismatch_count++;
                end
                if (o_colour_slot !== want.slot) begin
                    $error("colour_slot: expected %0d, actual %0d", want.slot, o_colour_slot);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial begin
        t_pix_item  it;
        t_pix_item  pre;
        logic [7:0] tile;
        int         phase_end;
        int         rounds;
        int         waited;
        i_rst_n           = 1'b0;
        start             = 1'b0;
        i_func            = FUNC_WR_PATTERN;
        i_pattern_address = '0;
        i_write_byte      = '0;
        i_cell_col        = '0;
        i_cell_row        = '0;
        i_palette_slot    = '0;
        i_palette_index   = '0;
        i_tile_id         = '0;
        i_pixel_row       = '0;
        i_pixel_col       = '0;
        i_colour_mode     = MODE_CELL;
        i_cfg_we          = 1'b0;
        i_cfg_data        = '0;
        brush_model       = BRUSH_RESET;
        rounds            = 0;
        foreach (pat_bytes[k]) begin
            pat_bytes[k]  = '0;
            pat_loaded[k] = 1'b0;
        end
        foreach (map_tiles[k]) map_tiles[k] = '0;
        foreach (cell_colours[k]) cell_colours[k] = '0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table at the reset brush palette
        foreach (DIRECTED[k]) begin
            send_item(DIRECTED[k].it, DIRECTED[k].chk, DIRECTED[k].want);
            maybe_idle();
        end

        // random phases, each under its own brush palette
        for (int phase = 0; phase < 4; phase++) begin
            drain_pipe();
            case (phase)
                0: write_brush(16'hffff);
                1: write_brush(16'h0000);
                default: write_brush(16'($urandom));
            endcase
            phase_end = DIR_ROWS + (phase + 1) * (ITEM_TOTAL - DIR_ROWS) / 4;
            while (items_sent < phase_end) begin
                if (rounds % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
                if (items_sent > ITEM_TOTAL - 100) idle_on = 1'b0;
                rounds++;
                it = random_item();
                // load the two plane bytes a render needs if never written
                if (it.func == FUNC_RENDER) begin
                    tile = render_tile(it);
                    for (int h = 0; h < 2; h++) begin
                        if (!pat_loaded[{tile, h[0], it.pixel_row}]) begin
                            pre                 = random_item();
                            pre.func            = FUNC_WR_PATTERN;
                            pre.pattern_address = {tile, h[0], it.pixel_row};
                            pre.write_byte      = 8'($urandom);
                            send_item(pre, 1'b0, '0);
                            maybe_idle();
                        end
                    end
                end
                send_item(it, 1'b0, '0);
                maybe_idle();
            end
        end

        // wind down
        start <= 1'b0;
        for (waited = 0; waited < 2000 && due_pixels.size() != 0; waited++)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_pixels.size() != 0) begin
            $error("%0d expected pixels never arrived", due_pixels.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
